// ===== src/tbwp_pkg.sv =====
// Shared types and constants of the tile background/window pixel unit.
// No dependencies; used by every module of the block but tbwp_ram.
package tbwp_pkg;

   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 144;
   localparam int VRAM_BYTES    = 8192;

   localparam int ADDR_W    = $clog2(VRAM_BYTES);
   localparam int ROW_W     = ADDR_W - 1;
   localparam int BANK_ROWS = VRAM_BYTES / 2;

   localparam logic [ADDR_W-1:0] SIGNED_DATA_BASE = ADDR_W'(16'h0800);

   // lcd_control bit positions
   localparam int LCDC_BG_ON    = 0;
   localparam int LCDC_BG_MAP   = 3;
   localparam int LCDC_DATA_SEL = 4;
   localparam int LCDC_WIN_ON   = 5;
   localparam int LCDC_WIN_MAP  = 6;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_RENDER = 1'b1;

   typedef enum logic [2:0] {
      CSR_LCD_CONTROL       = 3'd0,
      CSR_SCROLL_Y          = 3'd1,
      CSR_SCROLL_X          = 3'd2,
      CSR_BG_PALETTE        = 3'd3,
      CSR_WINDOW_TOP        = 3'd4,
      CSR_WINDOW_LEFT_PLUS7 = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] lcd_control;
      logic [7:0] scroll_y;
      logic [7:0] scroll_x;
      logic [7:0] bg_palette;
      logic [7:0] window_top;
      logic [7:0] window_left_plus7;
   } cfg_type;

   // Per-pixel context carried down the pipeline
   typedef struct packed {
      logic       covered;
      logic       map_odd;
      logic [2:0] fine_x;
      logic [2:0] fine_y;
   } pixel_ctx_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
      logic s1_free;
      logic s2_free;
      logic tile_re;
   } pipe_status_type;

endpackage

// ===== src/tbwp_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports with enable.
// Read-first on a same-address write. No dependencies.
module tbwp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_a_en,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   output logic [WIDTH-1:0]         rd_a_data,
   input  logic                     rd_b_en,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_b_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_data <= mem_ff[rd_a_addr];
      end
      if (rd_b_en) begin
         rd_b_data <= mem_ff[rd_b_addr];
      end
   end

endmodule

// ===== src/tbwp_locate.sv =====
// Accept-time pixel placement: window coverage, window line counter, map address.
// Depends on tbwp_pkg.
module tbwp_locate (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         render_accept,
   input  logic [7:0]                   line,
   input  logic [7:0]                   column,
   input  tbwp_pkg::cfg_type            cfg,
   output logic [tbwp_pkg::ROW_W-1:0]   map_row,
   output tbwp_pkg::pixel_ctx_type      ctx
);

   localparam logic [8:0] HEIGHT_LIMIT = 9'(tbwp_pkg::SCREEN_HEIGHT);
   localparam logic [8:0] LEFT_LIMIT   = 9'(tbwp_pkg::SCREEN_WIDTH + 7);
   localparam logic [7:0] LAST_COL     = 8'(tbwp_pkg::SCREEN_WIDTH - 1);

   logic [7:0] wlc_ff, wlc_in;
   logic       seen_ff, seen_in;

   logic       col_first, frame_first;
   logic [7:0] wlc_eff;
   logic       seen_eff, seen_mid;
   logic       line_active, covered;
   logic [8:0] col_plus7, win_diff;
   logic [7:0] bg_x, bg_y, sel_x, sel_y;
   logic       map_hi;
   logic [tbwp_pkg::ADDR_W-1:0] map_addr;

   always_comb begin
      col_first   = (column == 8'd0);
      frame_first = col_first && (line == 8'd0);
      wlc_eff     = frame_first ? 8'd0 : wlc_ff;
      seen_eff    = col_first ? 1'b0 : seen_ff;

      line_active = cfg.lcd_control[tbwp_pkg::LCDC_WIN_ON]
                    && ({1'b0, cfg.window_top} < HEIGHT_LIMIT)
                    && ({1'b0, cfg.window_left_plus7} < LEFT_LIMIT)
                    && (line >= cfg.window_top);
      col_plus7   = {1'b0, column} + 9'd7;
      covered     = line_active && (col_plus7 >= {1'b0, cfg.window_left_plus7});
      win_diff    = col_plus7 - {1'b0, cfg.window_left_plus7};

      bg_y   = line + cfg.scroll_y;
      bg_x   = column + cfg.scroll_x;
      sel_x  = covered ? win_diff[7:0] : bg_x;
      sel_y  = covered ? wlc_eff : bg_y;
      map_hi = covered ? cfg.lcd_control[tbwp_pkg::LCDC_WIN_MAP]
                       : cfg.lcd_control[tbwp_pkg::LCDC_BG_MAP];

      // map base is 0x1800 or 0x1C00, then 32 entries per tile row
      map_addr = {2'b11, map_hi, sel_y[7:3], sel_x[7:3]};
      map_row  = map_addr[tbwp_pkg::ADDR_W-1:1];

      ctx.covered = covered;
      ctx.map_odd = map_addr[0];
      ctx.fine_x  = sel_x[2:0];
      ctx.fine_y  = sel_y[2:0];

      seen_mid = seen_eff | line_active;
      if (column == LAST_COL) begin
         wlc_in  = seen_mid ? wlc_eff + 8'd1 : wlc_eff;
         seen_in = 1'b0;
      end else begin
         wlc_in  = wlc_eff;
         seen_in = seen_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlc_ff  <= 8'd0;
         seen_ff <= 1'b0;
      end else if (render_accept) begin
         wlc_ff  <= wlc_in;
         seen_ff <= seen_in;
      end
   end

endmodule

// ===== src/tbwp_shade.sv =====
// Pixel pipeline after the map read: tile row fetch, bit pick, palette, output register.
// Depends on tbwp_pkg; read data comes from the two tbwp_ram banks.
module tbwp_shade (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         render_accept,
   input  tbwp_pkg::pixel_ctx_type      ctx_in,
   input  tbwp_pkg::cfg_type            cfg,
   input  logic [7:0]                   map_even,
   input  logic [7:0]                   map_odd,
   input  logic [7:0]                   tile_lo,
   input  logic [7:0]                   tile_hi,
   input  logic                         rsp_stall,
   output logic [tbwp_pkg::ROW_W-1:0]   tile_row,
   output tbwp_pkg::pipe_status_type    status,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_shade,
   output logic                         rsp_from_window
);

   logic                    s1_valid_ff, s2_valid_ff, out_valid_ff;
   tbwp_pkg::pixel_ctx_type s1_ctx_ff, s2_ctx_ff;
   logic [1:0]              shade_ff, shade_in;
   logic                    from_window_ff;

   logic                    out_ready, s2_free, s1_free;
   logic [7:0]              tile_index;
   logic [tbwp_pkg::ADDR_W-1:0] tile_addr;
   logic [2:0]              bit_sel;
   logic [1:0]              raw;

   always_comb begin
      out_ready = !out_valid_ff || !rsp_stall;
      s2_free   = !s2_valid_ff || out_ready;
      s1_free   = !s1_valid_ff || s2_free;

      tile_index = s1_ctx_ff.map_odd ? map_odd : map_even;
      if (cfg.lcd_control[tbwp_pkg::LCDC_DATA_SEL]) begin
         tile_addr = {1'b0, tile_index, s1_ctx_ff.fine_y, 1'b0};
      end else begin
         // signed addressing: index + 128 from 0x0800
         tile_addr = tbwp_pkg::SIGNED_DATA_BASE
                     + {1'b0, ~tile_index[7], tile_index[6:0], s1_ctx_ff.fine_y, 1'b0};
      end
      tile_row = tile_addr[tbwp_pkg::ADDR_W-1:1];

      bit_sel  = ~s2_ctx_ff.fine_x;
      raw      = {tile_hi[bit_sel], tile_lo[bit_sel]};
      shade_in = cfg.lcd_control[tbwp_pkg::LCDC_BG_ON] ? cfg.bg_palette[{raw, 1'b0} +: 2]
                                                       : 2'd0;

      status.s1_valid = s1_valid_ff;
      status.s2_valid = s2_valid_ff;
      status.s1_free  = s1_free;
      status.s2_free  = s2_free;
      status.tile_re  = s1_valid_ff && s2_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= render_accept;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_ctx_ff <= ctx_in;
      end
      if (s2_free) begin
         s2_ctx_ff <= s1_ctx_ff;
      end
      if (out_ready) begin
         shade_ff       <= shade_in;
         from_window_ff <= s2_ctx_ff.covered;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_shade       = shade_ff;
   assign rsp_from_window = from_window_ff;

endmodule

// ===== src/tile_background_window_pixel.sv =====
// Tile background/window pixel unit: top level with config registers and VRAM banks.
// Depends on tbwp_pkg, tbwp_ram, tbwp_locate and tbwp_shade.
//
// Takes one item per cycle, writes and pixels alike, while req_stall is low. A write beat
// lands in video memory at the edge it is taken. A pixel beat passes through the map byte
// read, the tile row read and the output register, in that order; the last holds its result.
// Video memory is split into an even and an odd byte bank with two read ports each, so the
// low and high bytes of a tile row come out together and the map read of one pixel overlaps
// the tile read of the one before. Up to three pixels are in flight; when the result side
// stalls, the pipeline fills and then stalls the request side. Video memory is not cleared
// by reset.
module tile_background_window_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [12:0] req_vram_address,
   input  logic [7:0]  req_vram_data,
   input  logic [7:0]  req_screen_line,
   input  logic [7:0]  req_screen_column,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_shade,
   output logic        rsp_from_window,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   tbwp_pkg::cfg_type         cfg_ff;
   tbwp_pkg::pixel_ctx_type   ctx;
   tbwp_pkg::pipe_status_type status;

   logic                        accept, render_accept, write_accept;
   logic [tbwp_pkg::ROW_W-1:0]  map_row, tile_row, wr_row;
   logic [7:0]                  map_even, map_odd, tile_lo, tile_hi;

   assign csr_ready     = 1'b1;
   assign req_stall     = !status.s1_free;
   assign accept        = req_valid && !req_stall;
   assign render_accept = accept && (req_action == tbwp_pkg::ACTION_RENDER);
   assign write_accept  = accept && (req_action == tbwp_pkg::ACTION_WRITE);
   assign wr_row        = req_vram_address[tbwp_pkg::ADDR_W-1:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (tbwp_pkg::csr_index_type'(csr_index))
            tbwp_pkg::CSR_LCD_CONTROL:       cfg_ff.lcd_control       <= csr_data;
            tbwp_pkg::CSR_SCROLL_Y:          cfg_ff.scroll_y          <= csr_data;
            tbwp_pkg::CSR_SCROLL_X:          cfg_ff.scroll_x          <= csr_data;
            tbwp_pkg::CSR_BG_PALETTE:        cfg_ff.bg_palette        <= csr_data;
            tbwp_pkg::CSR_WINDOW_TOP:        cfg_ff.window_top        <= csr_data;
            tbwp_pkg::CSR_WINDOW_LEFT_PLUS7: cfg_ff.window_left_plus7 <= csr_data;
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   tbwp_locate u_locate (
      .clock         (clock),
      .reset         (reset),
      .render_accept (render_accept),
      .line          (req_screen_line),
      .column        (req_screen_column),
      .cfg           (cfg_ff),
      .map_row       (map_row),
      .ctx           (ctx)
   );

   tbwp_ram #(
      .WIDTH (8),
      .DEPTH (tbwp_pkg::BANK_ROWS)
   ) u_bank_even (
      .clock     (clock),
      .wr_en     (write_accept && !req_vram_address[0]),
      .wr_addr   (wr_row),
      .wr_data   (req_vram_data),
      .rd_a_en   (render_accept),
      .rd_a_addr (map_row),
      .rd_a_data (map_even),
      .rd_b_en   (status.tile_re),
      .rd_b_addr (tile_row),
      .rd_b_data (tile_lo)
   );

   tbwp_ram #(
      .WIDTH (8),
      .DEPTH (tbwp_pkg::BANK_ROWS)
   ) u_bank_odd (
      .clock     (clock),
      .wr_en     (write_accept && req_vram_address[0]),
      .wr_addr   (wr_row),
      .wr_data   (req_vram_data),
      .rd_a_en   (render_accept),
      .rd_a_addr (map_row),
      .rd_a_data (map_odd),
      .rd_b_en   (status.tile_re),
      .rd_b_addr (tile_row),
      .rd_b_data (tile_hi)
   );

   tbwp_shade u_shade (
      .clock           (clock),
      .reset           (reset),
      .render_accept   (render_accept),
      .ctx_in          (ctx),
      .cfg             (cfg_ff),
      .map_even        (map_even),
      .map_odd         (map_odd),
      .tile_lo         (tile_lo),
      .tile_hi         (tile_hi),
      .rsp_stall       (rsp_stall),
      .tile_row        (tile_row),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_shade       (rsp_shade),
      .rsp_from_window (rsp_from_window)
   );

   // a taken pixel beat always occupies the map stage next cycle
   a_render_enters: assert property (@(posedge clock) disable iff (reset)
      render_accept |=> status.s1_valid)
      else $error("pixel beat lost after map read");

   // a pixel waiting on a full output register must stay put
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (status.s2_valid && !status.s2_free) |=> status.s2_valid)
      else $error("tile stage dropped a held pixel");

   // a result leaves only if the tile stage had one to replace it, else output empties
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !status.s2_valid) |=> !rsp_valid)
      else $error("result appeared without a pixel behind it");

   // no memory write may slip past a pixel still waiting for its tile read
   a_write_order: assert property (@(posedge clock) disable iff (reset)
      (status.s1_valid && !status.s2_free) |-> !write_accept)
      else $error("write overtook a pending tile read");

endmodule

// ===== dv/tile_background_window_pixel_tb.sv =====
// Self-checking testbench for tile_background_window_pixel: video memory writes and pixel beats.
// Depends on tbwp_pkg and the RTL. It predicts each shade from a shadow of video memory,
// the registers and the window line counter.
module tile_background_window_pixel_tb;

   localparam int MAP_LOW_BASE  = 'h1800;
   localparam int MAP_HIGH_BASE = 'h1C00;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 100;
   localparam int HOLD_PHASE    = 1;
   localparam int PAUSE_PHASE   = 4;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int WATCHDOG_TIME = 5_000_000;

   typedef struct packed {
      logic        action;
      logic [12:0] vram_address;
      logic [7:0]  vram_data;
      logic [7:0]  screen_line;
      logic [7:0]  screen_column;
   } pixel_req_type;

   typedef struct packed {
      logic [1:0] shade;
      logic       from_window;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = tbwp_pkg::ACTION_WRITE;
   logic [12:0] req_vram_address = '0;
   logic [7:0]  req_vram_data = '0;
   logic [7:0]  req_screen_line = '0;
   logic [7:0]  req_screen_column = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_shade;
   logic        rsp_from_window;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = tbwp_pkg::CSR_LCD_CONTROL;
   logic [7:0]  csr_data = '0;

   // shadow of the block's state
   logic [7:0]        vram_copy [tbwp_pkg::VRAM_BYTES];
   tbwp_pkg::cfg_type cfg_copy = '0;
   logic [7:0]        win_line_count = '0;
   logic              win_seen = 1'b0;

   pixel_req_type    pending_beats [$];
   pixel_req_type    on_wire;
   pixel_result_type expected_pixels [$];

   int   send_idle_pct = 20;
   int   recv_idle_pct = 51;
   logic sender_paused = 1'b0;
   logic results_held = 1'b0;
   int   phase_no = -1;
   int   fail_count = 0;

   tile_background_window_pixel dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_vram_address  (req_vram_address),
      .req_vram_data     (req_vram_data),
      .req_screen_line   (req_screen_line),
      .req_screen_column (req_screen_column),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_shade         (rsp_shade),
      .rsp_from_window   (rsp_from_window),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Raw 2-bit pixel of the tile whose map entry sits at map_addr.
   function automatic logic [1:0] tile_raw(int map_addr, int px, int py);
      int         idx;
      int         row_addr;
      int         bitpos;
      logic [7:0] lo;
      logic [7:0] hi;
      idx = int'(vram_copy[13'(map_addr % tbwp_pkg::VRAM_BYTES)]);
      row_addr = 0;
      if (!cfg_copy.lcd_control[tbwp_pkg::LCDC_DATA_SEL]) begin
         idx = (idx + 128) % 256;
         row_addr = int'(tbwp_pkg::SIGNED_DATA_BASE);
      end
      row_addr = row_addr + idx * 16 + 2 * (py % 8);
      lo = vram_copy[13'(row_addr % tbwp_pkg::VRAM_BYTES)];
      hi = vram_copy[13'((row_addr + 1) % tbwp_pkg::VRAM_BYTES)];
      bitpos = 7 - (px % 8);
      return {hi[3'(bitpos)], lo[3'(bitpos)]};
   endfunction

   // Shade of one pixel; advances the window line counter as the block does.
   function automatic pixel_result_type render_pixel(int scan_line, int col);
      pixel_result_type res;
      logic             line_active;
      logic [1:0]       raw;
      int               wx;
      int               wy;
      int               bx;
      int               by;
      int               map_base;
      if (col == 0) begin
         if (scan_line == 0)
            win_line_count = '0;
         win_seen = 1'b0;
      end
      line_active = cfg_copy.lcd_control[tbwp_pkg::LCDC_WIN_ON]
         && int'(cfg_copy.window_top) < tbwp_pkg::SCREEN_HEIGHT
         && int'(cfg_copy.window_left_plus7) < tbwp_pkg::SCREEN_WIDTH + 7
         && scan_line >= int'(cfg_copy.window_top);
      res.from_window = line_active && (col + 7 >= int'(cfg_copy.window_left_plus7));
      if (line_active)
         win_seen = 1'b1;
      if (res.from_window) begin
         wx = col + 7 - int'(cfg_copy.window_left_plus7);
         wy = int'(win_line_count);
         map_base = cfg_copy.lcd_control[tbwp_pkg::LCDC_WIN_MAP] ? MAP_HIGH_BASE
                                                                 : MAP_LOW_BASE;
         raw = tile_raw(map_base + 32 * ((wy / 8) % 32) + ((wx / 8) % 32), wx, wy);
      end else begin
         by = (scan_line + int'(cfg_copy.scroll_y)) % 256;
         bx = (col + int'(cfg_copy.scroll_x)) % 256;
         map_base = cfg_copy.lcd_control[tbwp_pkg::LCDC_BG_MAP] ? MAP_HIGH_BASE
                                                                : MAP_LOW_BASE;
         raw = tile_raw(map_base + 32 * (by / 8) + bx / 8, bx, by);
      end
      res.shade = cfg_copy.lcd_control[tbwp_pkg::LCDC_BG_ON]
                  ? cfg_copy.bg_palette[{raw, 1'b0} +: 2] : 2'b00;
      if (col == tbwp_pkg::SCREEN_WIDTH - 1) begin
         if (win_seen)
            win_line_count = win_line_count + 8'd1;
         win_seen = 1'b0;
      end
      return res;
   endfunction

   task automatic note_failure(string msg);
      if (fail_count < REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Driver: hold a stalled beat, otherwise offer the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (on_wire.action == tbwp_pkg::ACTION_WRITE)
               vram_copy[on_wire.vram_address] = on_wire.vram_data;
            else
               expected_pixels.insert(expected_pixels.size(),
                                      render_pixel(int'(on_wire.screen_line),
                                                   int'(on_wire.screen_column)));
         end
         if (!req_valid || !req_stall) begin
            if (pending_beats.size() != 0 && !sender_paused
                && $urandom_range(99) >= send_idle_pct) begin
               on_wire = pending_beats.pop_front();
               req_action        <= on_wire.action;
               req_vram_address  <= on_wire.vram_address;
               req_vram_data     <= on_wire.vram_data;
               req_screen_line   <= on_wire.screen_line;
               req_screen_column <= on_wire.screen_column;
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result beat with the oldest predicted pixel.
   always @(posedge clock) begin : result_monitor
      pixel_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            note_failure($sformatf("result with no pixel pending: shade %0d window %0d",
                                   rsp_shade, rsp_from_window));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_shade !== want.shade || rsp_from_window !== want.from_window)
               note_failure($sformatf(
                  "pixel mismatch: expected shade %0d window %0d, got shade %0d window %0d",
                  want.shade, want.from_window, rsp_shade, rsp_from_window));
         end
      end
      rsp_stall <= results_held || ($urandom_range(99) < recv_idle_pct);
   end

   function automatic void push_write(int addr, int data);
      pixel_req_type b;
      b = '0;
      b.action = tbwp_pkg::ACTION_WRITE;
      b.vram_address = addr[12:0];
      b.vram_data = data[7:0];
      b.screen_line = 8'($urandom_range(255));
      b.screen_column = 8'($urandom_range(255));
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   function automatic void push_pixel(int scan_line, int col);
      pixel_req_type b;
      b = '0;
      b.action = tbwp_pkg::ACTION_RENDER;
      b.vram_address = 13'($urandom_range(tbwp_pkg::VRAM_BYTES - 1));
      b.vram_data = 8'($urandom_range(255));
      b.screen_line = scan_line[7:0];
      b.screen_column = col[7:0];
      pending_beats.insert(pending_beats.size(), b);
   endfunction

   task automatic csr_write(tbwp_pkg::csr_index_type idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         tbwp_pkg::CSR_LCD_CONTROL:       cfg_copy.lcd_control = value;
         tbwp_pkg::CSR_SCROLL_Y:          cfg_copy.scroll_y = value;
         tbwp_pkg::CSR_SCROLL_X:          cfg_copy.scroll_x = value;
         tbwp_pkg::CSR_BG_PALETTE:        cfg_copy.bg_palette = value;
         tbwp_pkg::CSR_WINDOW_TOP:        cfg_copy.window_top = value;
         tbwp_pkg::CSR_WINDOW_LEFT_PLUS7: cfg_copy.window_left_plus7 = value;
         default: ;
      endcase
   endtask

   task automatic write_config(logic [7:0] lcdc, logic [7:0] scy, logic [7:0] scx,
                               logic [7:0] pal, logic [7:0] wtop, logic [7:0] wleft);
      csr_write(tbwp_pkg::CSR_LCD_CONTROL, lcdc);
      csr_write(tbwp_pkg::CSR_SCROLL_Y, scy);
      csr_write(tbwp_pkg::CSR_SCROLL_X, scx);
      csr_write(tbwp_pkg::CSR_BG_PALETTE, pal);
      csr_write(tbwp_pkg::CSR_WINDOW_TOP, wtop);
      csr_write(tbwp_pkg::CSR_WINDOW_LEFT_PLUS7, wleft);
      @(negedge clock);
   endtask

   // Wait for every beat and result, then let the pipeline run dry.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly scan lines (start, a few ascending columns, end) in frames from line 0,
   // mixed with memory writes, stray pixels and lines missing a start or an end.
   task automatic queue_random_items(int n);
      int count;
      int scan_line;
      int col;
      int pick;
      count = 0;
      scan_line = 0;
      while (count < n) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            push_pixel(scan_line, 0);
            count++;
            col = 0;
            repeat ($urandom_range(5)) begin
               col = col + $urandom_range(1, 40);
               if (col < tbwp_pkg::SCREEN_WIDTH - 1) begin
                  push_pixel(scan_line, col);
                  count++;
               end
            end
            push_pixel(scan_line, tbwp_pkg::SCREEN_WIDTH - 1);
            count++;
            scan_line = scan_line + $urandom_range(1, 16);
            if (scan_line >= tbwp_pkg::SCREEN_HEIGHT)
               scan_line = 0;
         end else if (pick < 82) begin
            // favor the maps so tiles change under the scan
            if ($urandom_range(1))
               push_write($urandom_range(tbwp_pkg::VRAM_BYTES - 1, MAP_LOW_BASE),
                          $urandom_range(255));
            else
               push_write($urandom_range(tbwp_pkg::VRAM_BYTES - 1), $urandom_range(255));
            count++;
         end else if (pick < 92) begin
            push_pixel($urandom_range(255), $urandom_range(255));
            count++;
         end else begin
            push_pixel(scan_line, $urandom_range(tbwp_pkg::SCREEN_WIDTH - 2, 1));
            count++;
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] lcdc;
      logic [7:0] wtop;
      logic [7:0] wleft;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill all of video memory so no pixel reads an unwritten byte
      for (int a = 0; a < tbwp_pkg::VRAM_BYTES; a++)
         push_write(a, $urandom_range(255));
      wait_idle();

      // window from column 0, both scrolls at their top value
      write_config(8'hFF, 8'hFF, 8'hFF, 8'hE4, 8'd0, 8'd0);
      push_write(13'h0000, 8'h00);
      push_write(13'h1FFF, 8'hFF);
      push_pixel(0, 0);
      push_pixel(0, 80);
      push_pixel(0, 159);
      push_pixel(1, 0);
      push_pixel(1, 159);
      push_pixel(2, 0);
      push_pixel(255, 255);
      push_pixel(143, 159);
      wait_idle();

      // background off, window on the last line and last column only
      write_config(8'h20, 8'h00, 8'h00, 8'hFF, 8'd143, 8'd166);
      push_pixel(0, 0);
      push_pixel(142, 159);
      push_pixel(143, 0);
      push_pixel(143, 158);
      push_pixel(143, 159);
      push_pixel(144, 159);
      wait_idle();

      // window enabled but below the screen
      write_config(8'h31, 8'h80, 8'h7F, 8'h1B, 8'd144, 8'd10);
      push_pixel(0, 0);
      push_pixel(200, 100);
      push_pixel(10, 159);
      wait_idle();

      // window enabled but right of the screen
      write_config(8'h31, 8'h80, 8'h7F, 8'h1B, 8'd0, 8'd167);
      push_pixel(5, 0);
      push_pixel(5, 159);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            write_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         end else if (p == RANDOM_PHASES - 1) begin
            write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
         end else begin
            lcdc = 8'($urandom_range(255));
            if ($urandom_range(3) != 0) begin
               lcdc[tbwp_pkg::LCDC_WIN_ON] = 1'b1;
               lcdc[tbwp_pkg::LCDC_BG_ON] = 1'b1;
            end
            wtop = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(40));
            wleft = 8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(166));
            write_config(lcdc, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), wtop, wleft);
         end
         if (p == 3) begin
            send_idle_pct = 51;
            recv_idle_pct = 20;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         phase_no = p;
         queue_random_items(PHASE_ITEMS);
         if (p == PAUSE_PHASE) begin
            while (pending_beats.size() > PHASE_ITEMS / 2)
               @(negedge clock);
            sender_paused = 1'b1;
            while (expected_pixels.size() != 0 || req_valid)
               @(negedge clock);
            sender_paused = 1'b0;
         end
         wait_idle();
      end

      if (fail_count == 0 && expected_pixels.size() == 0)
         $display("** tile_background_window_pixel: PASSED **");
      else
         $display("** tile_background_window_pixel: FAILED **");
      $finish;
   end

   // Stall the result side for a long stretch so the pipeline backs up into the input.
   initial begin : long_result_hold
      wait (phase_no == HOLD_PHASE);
      @(posedge clock);
      results_held <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      results_held <= 1'b0;
   end

   initial begin : watchdog
      #(WATCHDOG_TIME);
      $display("** tile_background_window_pixel: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
src/tbwp_pkg.sv
src/tbwp_ram.sv
src/tbwp_locate.sv
src/tbwp_shade.sv
src/tile_background_window_pixel.sv
dv/tile_background_window_pixel_tb.sv
